// ===== hdl/firrb_pkg.sv =====
// ============================================================================
// firrb_pkg: shared types and constants for the ring-buffer FIR filter
// Fixed data widths, item function codes and the control word that travels
// with each tap through the multiply-accumulate pipeline.
// ============================================================================
package firrb_pkg;

   localparam int DATA_W  = 16;   // sample and coefficient width
   localparam int ACC_W   = 32;   // wrapping accumulator width
   localparam int SHIFT   = 16;   // output arithmetic shift
   localparam int CIDX_W  = 7;    // coefficient index field width

   // Item function codes.
   localparam logic FUNC_COEF   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Control that follows one tap through the datapath.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

// ===== hdl/firrb_store.sv =====
// ============================================================================
// firrb_store: sample ring and coefficient table
// Two single-port-write, registered-read memories. Ring entries carry a valid
// bit so that never-written entries read as zero after reset.
// ============================================================================
module firrb_store #(
   parameter int TAPS  = 101,
   parameter int IDX_W = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                ring_we,
   input  logic [IDX_W-1:0]                    ring_waddr,
   input  logic signed [firrb_pkg::DATA_W-1:0] ring_wdata,
   input  logic [IDX_W-1:0]                    ring_raddr,
   output logic signed [firrb_pkg::DATA_W-1:0] ring_rdata,
   input  logic                                coef_we,
   input  logic [IDX_W-1:0]                    coef_waddr,
   input  logic signed [firrb_pkg::DATA_W-1:0] coef_wdata,
   input  logic [IDX_W-1:0]                    coef_raddr,
   output logic signed [firrb_pkg::DATA_W-1:0] coef_rdata
);

   logic signed [firrb_pkg::DATA_W-1:0] ring_mem [TAPS];
   logic signed [firrb_pkg::DATA_W-1:0] coef_mem [TAPS];
   logic [TAPS-1:0]                     ring_vld_ff;
   logic signed [firrb_pkg::DATA_W-1:0] ring_q_ff;
   logic                                ring_hit_ff;
   logic signed [firrb_pkg::DATA_W-1:0] coef_q_ff;

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_q_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_q_ff <= coef_mem[coef_raddr];
   end

   // Valid bits stand in for clearing the ring at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         ring_hit_ff <= 1'b0;
      end else begin
         if (ring_we) begin
            ring_vld_ff[ring_waddr] <= 1'b1;
         end
         ring_hit_ff <= ring_vld_ff[ring_raddr];
      end
   end

   assign ring_rdata = ring_hit_ff ? ring_q_ff : '0;
   assign coef_rdata = coef_q_ff;

endmodule

// ===== hdl/firrb_mac.sv =====
// ============================================================================
// firrb_mac: multiply-accumulate pipeline
// One registered 16x16 product per cycle feeding a 32-bit wrapping
// accumulator; flags completion after the last tap.
// ============================================================================
module firrb_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  firrb_pkg::mac_ctl_type              ctl,
   input  logic signed [firrb_pkg::DATA_W-1:0] sample,
   input  logic signed [firrb_pkg::DATA_W-1:0] coef,
   output logic                                done,
   output logic signed [firrb_pkg::DATA_W-1:0] result
);

   firrb_pkg::mac_ctl_type             prod_ctl_ff;
   logic signed [firrb_pkg::ACC_W-1:0] prod_ff;
   logic signed [firrb_pkg::ACC_W-1:0] acc_ff;
   logic                               done_ff;

   always_ff @(posedge clock) begin
      prod_ff <= sample * coef;
      if (prod_ctl_ff.valid) begin
         acc_ff <= prod_ctl_ff.first ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         prod_ctl_ff <= ctl;
         done_ff     <= prod_ctl_ff.valid && prod_ctl_ff.last;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff[firrb_pkg::ACC_W-1 -: firrb_pkg::DATA_W];

endmodule

// ===== hdl/fir_filter_ring_buffer.sv =====
// ============================================================================
// fir_filter_ring_buffer: streaming FIR filter over a sample ring
// Coefficient items load one signed Q0.16 tap; sample items enter the ring and produce
// one filtered sample, tap 0 applied to the oldest stored sample.
// ============================================================================
//
//   Channel   Direction   Ports                                    Moves
//   req_      in          valid, stall, func, coef_index,          one item
//                         coef_value, sample_in
//   rsp_      out         valid, stall, sample_out                 one item
//
// A coefficient item is written into the table when accepted. For a sample item
// the sequencer reads one ring entry and one coefficient per cycle from the
// memories; each product passes the product and accumulator registers of the
// multiply-accumulate pipeline before the sum is handed to the output register.
// Reset is synchronous and active high; it clears the write pointer, the
// sequencer, the ring valid bits and the output valid bit. Coefficients are
// undefined until written.
// The output register lets a new item be accepted while a result still waits
// on rsp_stall; a finished sum waits for the register to free up.
// ============================================================================
module fir_filter_ring_buffer #(
   parameter int TAPS = 101
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [firrb_pkg::CIDX_W-1:0]        req_coef_index,
   input  logic signed [firrb_pkg::DATA_W-1:0] req_coef_value,
   input  logic signed [firrb_pkg::DATA_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [firrb_pkg::DATA_W-1:0] rsp_sample_out
);

   localparam int IDX_W = $clog2(TAPS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_PUT   = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    wp_ff, wp_in;
   logic [IDX_W-1:0]                    pos_ff, pos_in;
   logic [IDX_W-1:0]                    tap_ff, tap_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [firrb_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   firrb_pkg::mac_ctl_type              issue_ctl;
   firrb_pkg::mac_ctl_type              rd_ctl_ff;

   logic                                accept;
   logic                                take_sample;
   logic                                take_coef;
   logic                                out_free;
   logic [IDX_W-1:0]                    wp_next;
   logic signed [firrb_pkg::DATA_W-1:0] ring_rdata;
   logic signed [firrb_pkg::DATA_W-1:0] coef_rdata;
   logic                                mac_done;
   logic signed [firrb_pkg::DATA_W-1:0] mac_result;

   // Only the idle sequencer takes items; coefficient writes complete at once.
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign take_sample = accept && (req_func == firrb_pkg::FUNC_SAMPLE);
   // Writes to taps beyond the table are dropped.
   assign take_coef   = accept && (req_func == firrb_pkg::FUNC_COEF)
                        && (int'(req_coef_index) < TAPS);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign wp_next     = (wp_ff == LAST_IDX) ? '0 : wp_ff + 1'b1;

   // One tap is issued per cycle while running.
   always_comb begin
      issue_ctl.valid = (state_ff == ST_RUN);
      issue_ctl.first = (tap_ff == '0);
      issue_ctl.last  = (tap_ff == LAST_IDX);
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      pos_in       = pos_ff;
      tap_in       = tap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_sample) begin
               // The oldest sample sits just past the one now written.
               wp_in    = wp_next;
               pos_in   = wp_next;
               tap_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            pos_in = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
            tap_in = tap_ff + 1'b1;
            if (tap_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mac_result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ctl_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ctl_ff    <= issue_ctl;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      tap_ff      <= tap_in;
      rsp_data_ff <= rsp_data_in;
   end

   firrb_store #(
      .TAPS  (TAPS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ring_we    (take_sample),
      .ring_waddr (wp_ff),
      .ring_wdata (req_sample_in),
      .ring_raddr (pos_ff),
      .ring_rdata (ring_rdata),
      .coef_we    (take_coef),
      .coef_waddr (IDX_W'(req_coef_index)),
      .coef_wdata (req_coef_value),
      .coef_raddr (tap_ff),
      .coef_rdata (coef_rdata)
   );

   // The control word is registered once to line up with the registered read data.
   firrb_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rd_ctl_ff),
      .sample (ring_rdata),
      .coef   (coef_rdata),
      .done   (mac_done),
      .result (mac_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

`ifndef ASSERT_OFF
   // The accumulator finishes only while the sequencer waits for it.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_DRAIN))
      else $error("accumulator finished outside the drain state");

   // The write pointer always addresses a ring entry.
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      int'(wp_ff) < TAPS)
      else $error("write pointer beyond ring");

   // Issuing the last tap ends the run.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && tap_ff == LAST_IDX) |=> (state_ff == ST_DRAIN))
      else $error("run did not end after the last tap");

   // A new result never overwrites one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && state_ff == ST_PUT) |=> (state_ff == ST_PUT))
      else $error("result loaded into a busy output register");
`endif

endmodule
